@@ design/rdf_pkg.sv @@
// shared types, constants and helper functions of the radix-2 fft
`default_nettype none
package rdf_pkg;

	localparam int MaxLog2 = 6;
	localparam int Points  = 1 << MaxLog2;
	localparam int AddrW   = MaxLog2;
	localparam int DataW   = 24;

	localparam logic [1:0] CFG_LOG2  = 2'd0;
	localparam logic [1:0] CFG_SCALE = 2'd1;

	typedef struct packed {
		logic signed [15:0] sample_im;
		logic signed [15:0] sample_re;
	} sample_t;

	typedef struct packed {
		logic              last_bin;
		logic [5:0]        bin_index;
		logic signed [31:0] bin_im;
		logic signed [31:0] bin_re;
	} bin_t;

	typedef struct packed {
		logic signed [DataW-1:0] im;
		logic signed [DataW-1:0] re;
	} cplx_t;

	typedef struct packed {
		logic signed [15:0] wi;
		logic signed [15:0] wr;
	} tw_t;

	typedef struct packed {
		logic             valid;
		logic [AddrW-1:0] idx;
		logic             last;
	} bin_tag_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COPY,
		ST_COPY_END,
		ST_BF_RD,
		ST_BF_MUL,
		ST_BF_WR0,
		ST_BF_WR1,
		ST_OUT,
		ST_DRAIN
	} state_t;

	function automatic logic signed [15:0] cos_rom(input logic [4:0] k);
		logic signed [15:0] c;
		case (k)
			5'd0:    c = 16'sd32767;
			5'd1:    c = 16'sd32610;
			5'd2:    c = 16'sd32138;
			5'd3:    c = 16'sd31357;
			5'd4:    c = 16'sd30274;
			5'd5:    c = 16'sd28899;
			5'd6:    c = 16'sd27246;
			5'd7:    c = 16'sd25330;
			5'd8:    c = 16'sd23170;
			5'd9:    c = 16'sd20788;
			5'd10:   c = 16'sd18205;
			5'd11:   c = 16'sd15447;
			5'd12:   c = 16'sd12540;
			5'd13:   c = 16'sd9512;
			5'd14:   c = 16'sd6393;
			5'd15:   c = 16'sd3212;
			default: c = 16'sd0;
		endcase
		return c;
	endfunction

	// cos and -sin for k/64 of a turn
	function automatic tw_t twiddle(input logic [4:0] k);
		tw_t w;
		if (k <= 5'd16) begin
			w.wr = cos_rom(k);
			w.wi = -cos_rom(5'd16 - k);
		end else begin
			w.wr = -cos_rom(5'd0 - k);
			w.wi = -cos_rom(k - 5'd16);
		end
		return w;
	endfunction

	function automatic logic [2:0] eff_lg(input logic [2:0] l);
		logic [2:0] r;
		if (l == 3'd0)
			r = 3'd1;
		else if (l > 3'(MaxLog2))
			r = 3'(MaxLog2);
		else
			r = l;
		return r;
	endfunction

	function automatic logic [AddrW-1:0] bit_rev(input logic [AddrW-1:0] i,
		input logic [2:0] lg);
		logic [AddrW-1:0] r;
		int b;
		r = '0;
		for (b = 0; b < AddrW; b++) begin
			if (b < int'(lg))
				r[int'(lg) - 1 - b] = i[b];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ design/rdf_bfly.sv @@
// butterfly datapath: registered twiddle products, rounding and sum/difference
`default_nettype none
module rdf_bfly import rdf_pkg::*; (
	input  wire logic  clk,
	input  wire logic  en,
	input  wire cplx_t xa,
	input  wire cplx_t xb,
	input  wire tw_t   tw,
	output cplx_t      top,
	output cplx_t      bot
);

	logic signed [DataW+15:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	cplx_t xa_s1;
	logic signed [DataW+16:0] tr_full, ti_full;
	logic signed [DataW-1:0] tr, ti;

	always_ff @(posedge clk) begin
		if (en) begin
			p_rr_s1 <= tw.wr * xb.re;
			p_ii_s1 <= tw.wi * xb.im;
			p_ri_s1 <= tw.wr * xb.im;
			p_ir_s1 <= tw.wi * xb.re;
			xa_s1   <= xa;
		end
	end

	always_comb begin
		tr_full = (DataW+17)'(p_rr_s1) - (DataW+17)'(p_ii_s1) + (DataW+17)'(1 << 14);
		ti_full = (DataW+17)'(p_ri_s1) + (DataW+17)'(p_ir_s1) + (DataW+17)'(1 << 14);
		tr = tr_full[DataW+14:15];
		ti = ti_full[DataW+14:15];
		top.re = xa_s1.re + tr;
		top.im = xa_s1.im + ti;
		bot.re = xa_s1.re - tr;
		bot.im = xa_s1.im - ti;
	end

endmodule
`default_nettype wire

@@ design/rdf_scale.sv @@
// output scaler: q8.24 multiply, rounding and 32-bit saturation
`default_nettype none
module rdf_scale import rdf_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire bin_tag_t           tag,
	input  wire cplx_t              data,
	input  wire logic signed [31:0] scale,
	output bin_t                    result,
	output logic                    result_valid,
	output logic                    pipe_busy
);

	logic signed [DataW+31:0] pr_s1, pi_s1;
	bin_tag_t tag_s1;
	logic signed [DataW+32:0] tr, ti;
	logic signed [32:0] sr, si;

	function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v > 33'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -33'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1       <= '0;
			result_valid <= 1'b0;
		end else begin
			tag_s1       <= tag;
			result_valid <= tag_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		pr_s1       <= data.re * scale;
		pi_s1       <= data.im * scale;
		result.bin_re    <= sat32(sr);
		result.bin_im    <= sat32(si);
		result.bin_index <= 6'(tag_s1.idx);
		result.last_bin  <= tag_s1.last;
	end

	always_comb begin
		tr = (DataW+33)'(pr_s1) + (DataW+33)'(1 << 23);
		ti = (DataW+33)'(pi_s1) + (DataW+33)'(1 << 23);
		sr = tr[DataW+32:24];
		si = ti[DataW+32:24];
	end

	assign pipe_busy = tag_s1.valid;

endmodule
`default_nettype wire

@@ design/radix2_dit_fft_scaled_top.sv @@
// top level of the scaled radix-2 fft: frame memories, sequencer and datapaths
// Usage:
//   samples enter one beat at a time: a beat is taken at a clock edge where
//   start is high and busy is low. The beat that completes a frame of
//   N = 2^log2_points samples (0 counts as 1, 7 as 6) starts the transform and
//   raises busy. A frame then runs a bit-reversed copy, the (N/2)*log2(N)
//   butterflies (one work memory write port, two writes each) and the output.
//   Bins leave in order on result, one per cycle, each for exactly one cycle
//   with result_valid high; last_bin marks bin N-1. The receiver cannot stall.
//   busy falls the cycle after the last bin; the next frame may load at once.
//   Beats that do not complete a frame produce no result.
//   Configuration writes (cfg_valid, cfg_ready always high) go to index 0
//   (log2_points) or 1 (scale_factor); the user must make them while the block
//   is idle, as the block leaves this check to the user. Reset clears the sample
//   count and restores log2_points 6 and scale 1.0; memory is left uncleared.
`default_nettype none
module radix2_dit_fft_scaled_top import rdf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire sample_t     sample,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output bin_t             result,
	output logic             result_valid
);

	state_t state_q, state_d;
	logic [2:0] log2_q;
	logic signed [31:0] scale_q;
	logic [AddrW:0] load_q, load_next;
	logic [AddrW-1:0] cnt_q;
	logic [2:0] stage_q;
	logic [AddrW-2:0] bf_q;

	sample_t smem [Points];
	cplx_t   wmem [Points];
	sample_t srd;
	cplx_t   rd_a, rd_b;

	logic [2:0] lg;
	logic [AddrW-1:0] n_m1, half, j, a_addr, b_addr, kk, ra_addr, wr_addr;
	logic [AddrW-2:0] bf_last;
	logic acc, frame_done, cnt_last, bf_done, stage_done, we;
	cplx_t wr_data, top, bot;

	logic cv_s1, rv_s1, rlast_s1;
	logic [AddrW-1:0] caddr_s1, ridx_s1;
	bin_tag_t tag;
	logic scl_busy;

	assign cfg_ready = 1'b1;
	assign busy = (state_q != ST_IDLE);

	always_comb begin
		lg        = eff_lg(log2_q);
		n_m1      = AddrW'((7'd1 << lg) - 7'd1);
		bf_last   = n_m1[AddrW-1:1];
		acc       = start && !busy;
		load_next = load_q + 1'b1;
		frame_done = acc && (load_next >= ((AddrW+1)'(1) << lg));
		half      = AddrW'(1) << stage_q;
		j         = {1'b0, bf_q} & (half - AddrW'(1));
		a_addr    = ((({1'b0, bf_q}) >> stage_q) << (stage_q + 3'd1)) | j;
		b_addr    = a_addr | half;
		kk        = j << (3'd5 - stage_q);
		cnt_last  = (cnt_q == n_m1);
		bf_done   = (bf_q == bf_last);
		stage_done = (stage_q == lg - 3'd1);
		ra_addr   = (state_q == ST_OUT) ? cnt_q : a_addr;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_q  <= 3'd6;
			scale_q <= 32'sd16777216;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LOG2:  log2_q  <= cfg_data[2:0];
				CFG_SCALE: scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sample store
	always_ff @(posedge clk) begin
		if (acc)
			smem[load_q[AddrW-1:0]] <= sample;
		srd <= smem[bit_rev(cnt_q, lg)];
	end

	// work memory
	always_comb begin
		we      = 1'b0;
		wr_addr = a_addr;
		wr_data = top;
		if (cv_s1) begin
			we      = 1'b1;
			wr_addr = caddr_s1;
			wr_data.re = DataW'(srd.sample_re);
			wr_data.im = DataW'(srd.sample_im);
		end else if (state_q == ST_BF_WR0) begin
			we = 1'b1;
		end else if (state_q == ST_BF_WR1) begin
			we      = 1'b1;
			wr_addr = b_addr;
			wr_data = bot;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			wmem[wr_addr] <= wr_data;
		rd_a <= wmem[ra_addr];
		rd_b <= wmem[b_addr];
	end

	// state register and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			load_q   <= '0;
			cnt_q    <= '0;
			stage_q  <= '0;
			bf_q     <= '0;
			cv_s1    <= 1'b0;
			rv_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			cv_s1   <= (state_q == ST_COPY);
			rv_s1   <= (state_q == ST_OUT);
			if (acc)
				load_q <= frame_done ? '0 : load_next;
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
				end
				ST_COPY, ST_OUT: begin
					cnt_q <= cnt_q + 1'b1;
				end
				ST_COPY_END: begin
					stage_q <= '0;
					bf_q    <= '0;
					cnt_q   <= '0;
				end
				ST_BF_WR1: begin
					if (bf_done) begin
						bf_q <= '0;
						if (!stage_done)
							stage_q <= stage_q + 3'd1;
					end else begin
						bf_q <= bf_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		caddr_s1 <= cnt_q;
		ridx_s1  <= cnt_q;
		rlast_s1 <= cnt_last;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (frame_done) state_d = ST_COPY;
			ST_COPY:     if (cnt_last) state_d = ST_COPY_END;
			ST_COPY_END: state_d = ST_BF_RD;
			ST_BF_RD:    state_d = ST_BF_MUL;
			ST_BF_MUL:   state_d = ST_BF_WR0;
			ST_BF_WR0:   state_d = ST_BF_WR1;
			ST_BF_WR1:   state_d = (bf_done && stage_done) ? ST_OUT : ST_BF_RD;
			ST_OUT:      if (cnt_last) state_d = ST_DRAIN;
			ST_DRAIN:    if (!rv_s1 && !scl_busy) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	rdf_bfly u_bfly (
		.clk (clk),
		.en  (state_q == ST_BF_MUL),
		.xa  (rd_a),
		.xb  (rd_b),
		.tw  (twiddle(kk[4:0])),
		.top (top),
		.bot (bot)
	);

	always_comb begin
		tag.valid = rv_s1;
		tag.idx   = ridx_s1;
		tag.last  = rlast_s1;
	end

	rdf_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.tag          (tag),
		.data         (rd_a),
		.scale        (scale_q),
		.result       (result),
		.result_valid (result_valid),
		.pipe_busy    (scl_busy)
	);

`ifndef NO_ASSERTIONS
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		frame_done |=> busy) else $error("frame completion did not start transform");
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last_bin) |=> !result_valid)
		else $error("result after last bin");
	a_bf_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BF_WR0) |=> (state_q == ST_BF_WR1))
		else $error("butterfly write sequence broken");
	a_no_result_idle_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COPY) |-> !result_valid)
		else $error("result during copy");
`endif

endmodule
`default_nettype wire

@@ tb/radix2_dit_fft_scaled_top_tb.sv @@
// testbench of the scaled radix-2 fft: directed table and random frames checked against a predictor
`default_nettype none
module radix2_dit_fft_scaled_top_tb;
	import rdf_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	sample_t     sample = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	bin_t        result;
	logic        result_valid;

	radix2_dit_fft_scaled_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sample(sample),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .result(result), .result_valid(result_valid)
	);

	always #1 clk = ~clk;

	localparam int IdleLimit = 4000;

	bin_t            bins_due[$];
	logic [31:0]     frame_re[64];
	logic [31:0]     frame_im[64];
	int unsigned     held;
	logic [2:0]      size_reg;
	logic [31:0]     gain_reg;
	int              errors;
	int              idle_cycles;
	logic            finishing;

	function automatic int unsigned cur_lg();
		int unsigned l;
		l = size_reg;
		if (l < 1) l = 1;
		if (l > 6) l = 6;
		return l;
	endfunction

	function automatic longint rnd_shift(longint v, int s);
		longint t;
		t = v + (longint'(1) <<< (s - 1));
		return t >>> s;
	endfunction

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic void rot_factor(int unsigned k, output longint wr, output longint wi);
		int rom[17] = '{32767, 32610, 32138, 31357, 30274, 28899, 27246, 25330, 23170,
			20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};
		k = k & 31;
		if (k <= 16) begin
			wr = rom[k];
			wi = -rom[16 - k];
		end else begin
			wr = -rom[32 - k];
			wi = -rom[k - 16];
		end
	endfunction

	task automatic predict_bins(input sample_t s);
		longint re[64], im[64];
		longint wr, wi, tr, ti, scale;
		int unsigned lg, n, r, half;
		bin_t b;
		lg = cur_lg();
		n = 1 << lg;
		frame_re[held & 63] = 32'(s.sample_re);
		frame_im[held & 63] = 32'(s.sample_im);
		held = (held + 1) & 127;
		if (held < n) return;
		held = 0;
		scale = longint'($signed(gain_reg));
		for (int unsigned i = 0; i < n; i++) begin
			r = 0;
			for (int unsigned q = 0; q < lg; q++)
				if (i[q]) r |= 1 << (lg - 1 - q);
			re[i] = longint'($signed(frame_re[r]));
			im[i] = longint'($signed(frame_im[r]));
		end
		for (half = 1; half < n; half <<= 1)
			for (int unsigned i = 0; i < n; i++) begin
				if ((i & half) != 0) continue;
				rot_factor((i & (half - 1)) * (32 / half), wr, wi);
				tr = rnd_shift(wr * re[i + half] - wi * im[i + half], 15);
				ti = rnd_shift(wr * im[i + half] + wi * re[i + half], 15);
				re[i + half] = re[i] - tr;
				im[i + half] = im[i] - ti;
				re[i] += tr;
				im[i] += ti;
			end
		for (int unsigned i = 0; i < n; i++) begin
			b.bin_re = 32'(sat32(rnd_shift(re[i] * scale, 24)));
			b.bin_im = 32'(sat32(rnd_shift(im[i] * scale, 24)));
			b.bin_index = 6'(i);
			b.last_bin = (i == n - 1);
			bins_due.push_back(b);
		end
	endtask

	always @(posedge clk) begin
		if (result_valid) begin
			if (bins_due.size() == 0) begin
				$error("unexpected bin %0d", result.bin_index);
				errors++;
			end else begin
				bin_t e;
				e = bins_due.pop_front();
				if (result.bin_re !== e.bin_re) begin
					$error("bin_re expected %0d actual %0d", e.bin_re, result.bin_re);
					errors++;
				end
				if (result.bin_im !== e.bin_im) begin
					$error("bin_im expected %0d actual %0d", e.bin_im, result.bin_im);
					errors++;
				end
				if (result.bin_index !== e.bin_index) begin
					$error("bin_index expected %0d actual %0d", e.bin_index, result.bin_index);
					errors++;
				end
				if (result.last_bin !== e.last_bin) begin
					$error("last_bin expected %0d actual %0d", e.last_bin, result.last_bin);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no beat in either direction
	always @(posedge clk) begin
		if (!arst_n || result_valid || (start && !busy) || (cfg_valid && cfg_ready)
				|| finishing)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IdleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_sample(input sample_t s);
		int unsigned gap;
		gap = $urandom_range(0, 10);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		sample <= s;
		do @(posedge clk); while (busy);
		predict_bins(s);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		start <= 1'b0;
		while (bins_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_LOG2) size_reg = val[2:0];
		else gain_reg = val;
	endtask

	task automatic send_frames(input int unsigned count, input int unsigned mode);
		sample_t s;
		for (int unsigned i = 0; i < count; i++) begin
			s = sample_t'($urandom());
			case (mode)
				1: s = (i % 2) ? '{16'sh8000, 16'sh8000} : '{16'sh7fff, 16'sh7fff};
				2: s = $urandom_range(0, 1) ? '{16'sh7fff, 16'sh7fff} : '{16'sh8000, 16'sh8000};
				default: ;
			endcase
			send_sample(s);
		end
	endtask

	typedef struct {
		logic [2:0]  lg;
		logic [31:0] gain;
		int unsigned count;
		int unsigned mode;
	} phase_t;

	phase_t steps[] = '{
		'{3'd1, 32'h0100_0000, 2, 1},
		'{3'd0, 32'h7fff_ffff, 2, 1},
		'{3'd2, 32'h8000_0000, 4, 2},
		'{3'd7, 32'h0000_0000, 4, 0},
		'{3'd3, 32'hff00_0000, 8, 2}
	};

	initial begin
		errors = 0;
		held = 0;
		size_reg = 3'd6;
		gain_reg = 32'h0100_0000;
		finishing = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// reset size: one full 64-point frame of extremes
		send_frames(64, 2);
		foreach (steps[i]) begin
			write_reg(CFG_LOG2, {29'd0, steps[i].lg});
			write_reg(CFG_SCALE, steps[i].gain);
			send_frames(steps[i].count, steps[i].mode);
		end
		// shrink the size mid-frame
		write_reg(CFG_LOG2, 32'd3);
		send_frames(5, 0);
		write_reg(CFG_LOG2, 32'd2);
		send_frames(1, 0);
		for (int p = 0; p < 11; p++) begin
			write_reg(CFG_LOG2, (p % 5 == 4) ? 32'd6 : 32'($urandom_range(0, 4)));
			write_reg(CFG_SCALE, $urandom_range(0, 2) == 0 ? $urandom()
				: 32'($urandom_range(0, 32'h0400_0000)));
			send_frames(16, $urandom_range(0, 5) == 0 ? 2 : 0);
		end
		start <= 1'b0;
		finishing = 1'b1;
		fork
			while (bins_due.size() != 0) @(posedge clk);
			begin
				repeat (20000) @(posedge clk);
				$display("tb: failure");
				$finish;
			end
		join_any
		repeat (900) @(posedge clk);
		if (errors == 0 && bins_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire

@@ sim.f @@
design/rdf_pkg.sv
design/rdf_bfly.sv
design/rdf_scale.sv
design/radix2_dit_fft_scaled_top.sv
tb/radix2_dit_fft_scaled_top_tb.sv
